@@ design/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("assertion failed");

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");

`endif

@@ design/svds_pkg.sv @@
// shared constants, codes and control types of the sorted visited set
// no dependencies
package svds_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_W    = 32;
	localparam int DEPTH_W  = 8;

	localparam logic [1:0] OUT_INSERTED = 2'd0;
	localparam logic [1:0] OUT_LOWERED  = 2'd1;
	localparam logic [1:0] OUT_KNOWN    = 2'd2;
	localparam logic [1:0] OUT_FULL     = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic cmp;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic [1:0] outcome;
	} sts_t;

endpackage

@@ design/sorted_visited_set_with_depth.sv @@
// Sorted visited set: holds up to 64 keys in ascending order, each with the
// smallest depth seen. An offered beat is latched, compared against every
// entry at once in the next cycle, and committed (depth lowered, new key
// inserted with larger entries moved up one slot, or nothing changed for a
// known key or a full set) once the output register is free, when its result
// is loaded into that register. The next beat is taken at that commit edge,
// so one beat is in flight at a time; a stalled output holds the commit.
// No clearing pass: ready right after reset.
// depends on svds_pkg, svds_ctrl, svds_datapath
module sorted_visited_set_with_depth import svds_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [KEY_W-1:0]   hash_key,
	input  logic [DEPTH_W-1:0] search_depth,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         outcome,
	output logic               explore
);

	cmd_t cmd;
	sts_t sts;

	svds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.outcome   (outcome),
		.explore   (explore),
		.cmd       (cmd),
		.sts       (sts)
	);

	svds_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.hash_key     (hash_key),
		.search_depth (search_depth),
		.sts          (sts)
	);

endmodule

@@ design/svds_datapath.sv @@
// table of sorted keys and depths with one comparator per entry
// depends on svds_pkg
module svds_datapath import svds_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  logic [KEY_W-1:0]   hash_key,
	input  logic [DEPTH_W-1:0] search_depth,
	output sts_t               sts
);

	logic [KEY_W-1:0]   key_q   [CAPACITY];
	logic [DEPTH_W-1:0] depth_q [CAPACITY];
	logic [CNT_W-1:0]   count_q;

	logic [KEY_W-1:0]   key_s1;
	logic [DEPTH_W-1:0] depth_s1;

	logic [CAPACITY-1:0] ge_c, eq_c, gt_c;
	logic [CAPACITY-1:0] ge_s2, eq_s2, gt_s2;
	logic                full_s2;

	logic [CAPACITY-1:0] prev_ge, ins_sel;
	logic                found, lower;

	// latch the offered beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_s1   <= hash_key;
			depth_s1 <= search_depth;
		end
	end

	// per entry compare
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			logic vld;
			vld     = CNT_W'(i) < count_q;
			ge_c[i] = !vld || (key_q[i] >= key_s1);
			eq_c[i] = vld && (key_q[i] == key_s1);
			gt_c[i] = vld && (key_q[i] == key_s1) && (depth_q[i] > depth_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			ge_s2   <= ge_c;
			eq_s2   <= eq_c;
			gt_s2   <= gt_c;
			full_s2 <= count_q == CNT_W'(CAPACITY);
		end
	end

	assign prev_ge = {ge_s2[CAPACITY-2:0], 1'b0};
	assign ins_sel = ge_s2 & ~prev_ge;
	assign found   = |eq_s2;
	assign lower   = |gt_s2;

	always_comb begin
		if (full_s2)
			sts.outcome = OUT_FULL;
		else if (found && lower)
			sts.outcome = OUT_LOWERED;
		else if (found)
			sts.outcome = OUT_KNOWN;
		else
			sts.outcome = OUT_INSERTED;
	end

	// commit: lower a depth or shift up and insert
	always_ff @(posedge clk) begin
		if (cmd.commit && !full_s2) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (lower) begin
					if (gt_s2[i])
						depth_q[i] <= depth_s1;
				end else if (!found) begin
					if (ins_sel[i]) begin
						key_q[i]   <= key_s1;
						depth_q[i] <= depth_s1;
					end else if (prev_ge[i] && i > 0) begin
						key_q[i]   <= key_q[(i > 0) ? i - 1 : 0];
						depth_q[i] <= depth_q[(i > 0) ? i - 1 : 0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit && !full_s2 && !found) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

endmodule

@@ design/svds_ctrl.sv @@
// sequencer for load, compare and commit, and the result register
// depends on svds_pkg
module svds_ctrl import svds_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] outcome,
	output logic       explore,
	output cmd_t       cmd,
	input  sts_t       sts
);

	state_t     state_q, state_nxt;
	logic       out_valid_q;
	logic [1:0] outcome_q;
	logic       out_free, accept, commit;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_stall  = 1'b1;
		commit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid)
					state_nxt = ST_CMP;
			end
			ST_CMP: begin
				state_nxt = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (out_free) begin
					commit    = 1'b1;
					in_stall  = 1'b0;
					state_nxt = in_valid ? ST_CMP : ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign accept     = in_valid && !in_stall;
	assign cmd.load   = accept;
	assign cmd.cmp    = state_q == ST_CMP;
	assign cmd.commit = commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit)
			outcome_q <= sts.outcome;
	end

	assign out_valid = out_valid_q;
	assign outcome   = outcome_q;
	assign explore   = (outcome_q == OUT_INSERTED) || (outcome_q == OUT_LOWERED);

endmodule

@@ design/svds_checker.sv @@
// port level checks for the sorted visited set, bound to the top level
// depends on assert_macros.svh and svds_pkg
`include "assert_macros.svh"

module svds_checker import svds_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] outcome,
	input logic       explore
);

	logic explore_exp;

	assign explore_exp = (outcome == OUT_INSERTED) || (outcome == OUT_LOWERED);

	`ASSERT_CLK(a_explore_code, clk, arst_n, out_valid |-> (explore == explore_exp))
	`ASSERT_CLK(a_one_beat_in_flight, clk, arst_n, (in_valid && !in_stall) |=> in_stall)
	`ASSERT_CLK(a_result_latency, clk, arst_n, $rose(out_valid) |-> $past(in_valid && !in_stall, 3))
	`ASSERT_CLK(a_out_hold, clk, arst_n, (out_valid && out_stall) |=> (out_valid && $stable(outcome)))

endmodule

bind sorted_visited_set_with_depth svds_checker u_svds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.outcome   (outcome),
	.explore   (explore)
);
